// ----- hdl/rgbq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbq_pkg: shared types, weights and arithmetic for the quad color converter
// Beat formats for both channels, fixed-point weights, luma and chroma helpers.
// ----------------------------------------------------------------------------
package rgbq_pkg;

    // Fixed-point weights (luma in 1/256, chroma in 1/1024)
    localparam logic [7:0] W_YR       = 8'd76;
    localparam logic [7:0] W_YG       = 8'd150;
    localparam logic [7:0] W_YB       = 8'd29;
    localparam logic [7:0] W_VR       = 8'd182;
    localparam logic [7:0] W_UB       = 8'd144;
    localparam logic [7:0] CHROMA_MID = 8'd128;

    // Channel order register codes
    localparam logic ORDER_RGB   = 1'b0;
    localparam logic ORDER_BGR   = 1'b1;
    localparam logic ORDER_RESET = ORDER_BGR;

    // Input beat: one 2x2 quad, three channel bytes per pixel
    typedef struct packed {
        logic [7:0] tl_ch0;
        logic [7:0] tl_ch1;
        logic [7:0] tl_ch2;
        logic [7:0] tr_ch0;
        logic [7:0] tr_ch1;
        logic [7:0] tr_ch2;
        logic [7:0] bl_ch0;
        logic [7:0] bl_ch1;
        logic [7:0] bl_ch2;
        logic [7:0] br_ch0;
        logic [7:0] br_ch1;
        logic [7:0] br_ch2;
    } t_quad_in;

    // Output beat: four luma samples and one chroma pair
    typedef struct packed {
        logic [7:0] luma_tl;
        logic [7:0] luma_tr;
        logic [7:0] luma_bl;
        logic [7:0] luma_br;
        logic [7:0] chroma_v;
        logic [7:0] chroma_u;
    } t_yuv_out;

    // Weighted luma of 10-bit channel values, >> 8; result fits 10 bits
    function automatic logic [9:0] luma_of(input logic [9:0] r,
                                           input logic [9:0] g,
                                           input logic [9:0] b);
        logic [17:0] acc;
        acc = 18'(r) * 18'(W_YR) + 18'(g) * 18'(W_YG) + 18'(b) * 18'(W_YB);
        return acc[17:8];
    endfunction

    // floor(diff * weight / 1024) + 128, saturated to 0..255
    function automatic logic [7:0] chroma_of(input logic signed [10:0] diff,
                                             input logic [7:0]         weight);
        logic signed [19:0] prod;
        logic signed [11:0] v;
        prod = $signed({{9{diff[10]}}, diff}) * $signed({12'd0, weight});
        // arithmetic shift by 10 is a plain slice of the upper bits
        v    = $signed({{2{prod[19]}}, prod[19:10]}) + $signed({4'd0, CHROMA_MID});
        if (v < 0) begin
            return 8'd0;
        end else if (v > 12'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rgbq_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbq_core: combinational quad conversion
// Channel swap, per-pixel luma, quad channel sums, quad luma and chroma pair.
// ----------------------------------------------------------------------------
module rgbq_core (
    input  wire logic              i_order,
    input  wire rgbq_pkg::t_quad_in i_quad,
    output rgbq_pkg::t_yuv_out      o_yuv
);
    import rgbq_pkg::*;

    logic [7:0]         c0   [4];
    logic [7:0]         c1   [4];
    logic [7:0]         c2   [4];
    logic [7:0]         r    [4];
    logic [7:0]         b    [4];
    logic [9:0]         luma [4];
    logic [9:0]         sum_r;
    logic [9:0]         sum_g;
    logic [9:0]         sum_b;
    logic [9:0]         sum_y;
    logic signed [10:0] diff_v;
    logic signed [10:0] diff_u;

    // unpack pixels in tl, tr, bl, br order
    assign c0[0] = i_quad.tl_ch0;  assign c1[0] = i_quad.tl_ch1;  assign c2[0] = i_quad.tl_ch2;
    assign c0[1] = i_quad.tr_ch0;  assign c1[1] = i_quad.tr_ch1;  assign c2[1] = i_quad.tr_ch2;
    assign c0[2] = i_quad.bl_ch0;  assign c1[2] = i_quad.bl_ch1;  assign c2[2] = i_quad.bl_ch2;
    assign c0[3] = i_quad.br_ch0;  assign c1[3] = i_quad.br_ch1;  assign c2[3] = i_quad.br_ch2;

    // channel swap and per-pixel luma
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            r[p]    = (i_order == ORDER_BGR) ? c2[p] : c0[p];
            b[p]    = (i_order == ORDER_BGR) ? c0[p] : c2[p];
            luma[p] = luma_of({2'd0, r[p]}, {2'd0, c1[p]}, {2'd0, b[p]});
        end
    end

    // quad sums, 10 bits each
    assign sum_r = 10'(r[0])  + 10'(r[1])  + 10'(r[2])  + 10'(r[3]);
    assign sum_g = 10'(c1[0]) + 10'(c1[1]) + 10'(c1[2]) + 10'(c1[3]);
    assign sum_b = 10'(b[0])  + 10'(b[1])  + 10'(b[2])  + 10'(b[3]);
    assign sum_y = luma_of(sum_r, sum_g, sum_b);

    // color differences against the quad luma
    assign diff_v = $signed({1'b0, sum_r}) - $signed({1'b0, sum_y});
    assign diff_u = $signed({1'b0, sum_b}) - $signed({1'b0, sum_y});

    // pack the output beat
    assign o_yuv.luma_tl  = luma[0][7:0];
    assign o_yuv.luma_tr  = luma[1][7:0];
    assign o_yuv.luma_bl  = luma[2][7:0];
    assign o_yuv.luma_br  = luma[3][7:0];
    assign o_yuv.chroma_v = chroma_of(diff_v, W_VR);
    assign o_yuv.chroma_u = chroma_of(diff_u, W_UB);

endmodule
`default_nettype wire

// ----- hdl/rgb_quad_to_yuv420.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_quad_to_yuv420: 2x2 RGB/BGR quad to YUV 4:2:0 converter
// Input register, conversion logic, result register; one quad per clock unless the output stalls.
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+---------------------
//   quad in | in        | i_valid / o_ready         | i_data (t_quad_in)
//   yuv out | out       | o_valid / i_ready         | o_data (t_yuv_out)
//   config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_data[0] order
//
// An accepted quad passes the input register, then the result register, to the output beat; one quad per clock
// sustained while the output does not stall, set by the single conversion pass between the two registers.
// Synchronous active-low reset clears both stage valids and sets BGR order.
// A stalled output holds its beat; the input stage keeps accepting while the
// result register drains, so a stall backs up one stage at a time.
// ----------------------------------------------------------------------------
module rgb_quad_to_yuv420 (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // quad input
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire rgbq_pkg::t_quad_in  i_data,
    // yuv output
    output logic                     o_valid,
    input  wire logic                i_ready,
    output rgbq_pkg::t_yuv_out       o_data,
    // configuration
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [0:0]          i_cfg_data
);
    import rgbq_pkg::*;

    logic     r_order;
    logic     r_s1_valid;
    t_quad_in r_s1_quad;
    logic     r_out_valid;
    t_yuv_out r_out_data;
    t_yuv_out n_out_data;
    logic     s1_adv;

    // result register takes a beat when empty or being drained
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_s1_valid || s1_adv;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;

    // channel order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_valid) begin
            r_order <= i_cfg_data[0];
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_quad <= i_data;
        end
    end

    // conversion
    rgbq_core u_core (
        .i_order (r_order),
        .i_quad  (r_s1_quad),
        .o_yuv   (n_out_data)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // accepted quad lands in the input stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s1_valid)
        else $error("accepted quad missing from input stage");

    // blocked input stage keeps its beat
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_quad)))
        else $error("input stage lost a blocked beat");

    // advancing beat shows up at the output
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_valid)
        else $error("advanced beat missing at output");

    // config write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_order == $past(i_cfg_data[0])))
        else $error("channel order write not applied");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ----- tb/tb_rgb_quad_to_yuv420.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_quad_to_yuv420: self-checking bench for the quad color converter
// Directed quads (extremes, single-pixel and per-channel cases, both channel
// orders) followed by random quads in several phases. Each accepted quad's expected
// result, hand-worked or from a behavioral model, is compared with the output beats
// in order. Both sides idle at random, but for the second random phase, and the sink
// stalls long enough once to fill the block.
// ----------------------------------------------------------------------------
module tb_rgb_quad_to_yuv420;

    import rgbq_pkg::*;

    // Conversion weights (luma in 1/256, chroma in 1/1024)
    localparam int Y_WT_R      = 76;
    localparam int Y_WT_G      = 150;
    localparam int Y_WT_B      = 29;
    localparam int V_WT        = 182;
    localparam int U_WT        = 144;
    localparam int CHROMA_ZERO = 128;

    localparam int NUM_CASES    = 18;
    localparam int NUM_PHASES   = 4;
    localparam int PHASE_QUADS  = 250;
    localparam int SINK_HOLD    = 64;
    localparam int SETTLE_TICKS = 10;
    localparam int MAX_REPORTS  = 10;

    // Directed quad: channel order, beat, and an optional hand-worked result
    typedef struct packed {
        logic     order;
        t_quad_in quad;
        logic     typed;
        t_yuv_out yuv;
    } t_quad_case;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_quad_in i_data;
    logic     o_valid;
    logic     i_ready;
    t_yuv_out o_data;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    logic     i_cfg_data;

    t_yuv_out yuv_expect_q[$];
    int       fail_count = 0;
    logic     cur_order  = ORDER_RESET;
    bit       idle_on    = 1'b1;
    bit       hold_now   = 1'b0;

    // Directed quads: uniform quads replicate one pixel four times
    t_quad_case quad_cases [NUM_CASES] = '{
        '{ORDER_BGR, 96'h0,                            1'b1, 48'h00000000_8080},
        '{ORDER_BGR, {12{8'hFF}},                      1'b1, 48'hFEFEFEFE_8080},
        '{ORDER_BGR, {4{24'h0000FF}},                  1'b1, 48'h4B4B4B4B_FF55},
        '{ORDER_BGR, {4{24'hFF0000}},                  1'b1, 48'h1C1C1C1C_6BFF},
        '{ORDER_BGR, {4{24'h00FF00}},                  1'b0, 48'h0},
        '{ORDER_BGR, {4{24'hFFFF00}},                  1'b0, 48'h0},
        '{ORDER_BGR, 96'hFFFFFF_000000_000000_000000,  1'b0, 48'h0},
        '{ORDER_BGR, 96'h000000_FFFFFF_000000_000000,  1'b0, 48'h0},
        '{ORDER_BGR, 96'h000000_000000_FFFFFF_000000,  1'b0, 48'h0},
        '{ORDER_BGR, 96'h000000_000000_000000_FFFFFF,  1'b0, 48'h0},
        '{ORDER_BGR, 96'h55AA55_AA55AA_55AA55_AA55AA,  1'b0, 48'h0},
        '{ORDER_RGB, 96'h0,                            1'b1, 48'h00000000_8080},
        '{ORDER_RGB, {4{24'hFF0000}},                  1'b1, 48'h4B4B4B4B_FF55},
        '{ORDER_RGB, {4{24'h0000FF}},                  1'b1, 48'h1C1C1C1C_6BFF},
        '{ORDER_RGB, {4{24'hFFFF00}},                  1'b0, 48'h0},
        '{ORDER_RGB, 96'hAA55AA_55AA55_AA55AA_55AA55,  1'b0, 48'h0},
        '{ORDER_RGB, 96'h010203_FCFDFE_7F8081_800102,  1'b0, 48'h0},
        '{ORDER_RGB, {12{8'hFF}},                      1'b1, 48'hFEFEFEFE_8080}
    };

    rgb_quad_to_yuv420 i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------
    function automatic int weigh_luma(input int red, input int grn, input int blu);
        return (red * Y_WT_R + grn * Y_WT_G + blu * Y_WT_B) >>> 8;
    endfunction

    // floor(prod / 1024) + 128, clamped to a byte
    function automatic logic [7:0] chroma_sat(input int prod);
        int c;
        c = (prod >>> 10) + CHROMA_ZERO;
        if (c < 0) begin
            c = 0;
        end else if (c > 255) begin
            c = 255;
        end
        return 8'(c);
    endfunction

    function automatic t_yuv_out yuv_of_quad(input t_quad_in q, input logic order);
        logic [95:0] bits;
        logic [7:0]  luma [4];
        int          ch0, grn, ch2, red, blu;
        int          sum_r, sum_g, sum_b, quad_y;
        t_yuv_out    y;
        bits  = q;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        // pixel 0 (top-left) sits in the top bits
        for (int p = 0; p < 4; p++) begin
            ch0 = bits[95 - 24 * p -: 8];
            grn = bits[87 - 24 * p -: 8];
            ch2 = bits[79 - 24 * p -: 8];
            red = (order == ORDER_BGR) ? ch2 : ch0;
            blu = (order == ORDER_BGR) ? ch0 : ch2;
            luma[p] = 8'(weigh_luma(red, grn, blu));
            sum_r += red;
            sum_g += grn;
            sum_b += blu;
        end
        quad_y     = weigh_luma(sum_r, sum_g, sum_b);
        y.luma_tl  = luma[0];
        y.luma_tr  = luma[1];
        y.luma_bl  = luma[2];
        y.luma_br  = luma[3];
        y.chroma_v = chroma_sat((sum_r - quad_y) * V_WT);
        y.chroma_u = chroma_sat((sum_b - quad_y) * U_WT);
        return y;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    // random bytes, saturated bytes, or one pixel repeated over the quad
    function automatic t_quad_in rand_quad();
        logic [95:0] bits;
        logic [23:0] px;
        int          mode;
        mode = $urandom_range(0, 9);
        if (mode >= 8) begin
            for (int c = 0; c < 3; c++) begin
                px[c * 8 +: 8] = (mode == 8) ? 8'($urandom_range(0, 255))
                                             : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
            end
            bits = {4{px}};
        end else begin
            for (int i = 0; i < 12; i++) begin
                bits[i * 8 +: 8] = (mode < 6) ? 8'($urandom_range(0, 255))
                                              : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
            end
        end
        return t_quad_in'(bits);
    endfunction

    // offer one quad after a random gap; valid stays up once raised
    task automatic push_quad(input t_quad_in q, input t_yuv_out want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= q;
        do @(posedge i_clk); while (!o_ready);
        yuv_expect_q.push_back(want);
    endtask

    // drop valid and wait until every expected beat has come out
    task automatic quiesce();
        i_valid <= 1'b0;
        while (yuv_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // channel order write, only with the block empty
    task automatic set_order(input logic order);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= order;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_order = order;
    endtask

    // ------------------------------------------------------------------
    // Sink: random ready, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin
        int run;
        int gap;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_now) begin
                i_ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
                hold_now = 1'b0;
            end
            i_ready <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output check: each beat against the oldest expected result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_yuv_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (yuv_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected yuv beat %h", $realtime, o_data);
                end
            end else begin
                want = yuv_expect_q.pop_front();
                if (o_data.luma_tl  !== want.luma_tl  || o_data.luma_tr  !== want.luma_tr  ||
                    o_data.luma_bl  !== want.luma_bl  || o_data.luma_br  !== want.luma_br  ||
                    o_data.chroma_v !== want.chroma_v || o_data.chroma_u !== want.chroma_u) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: yuv mismatch exp Y=%h,%h,%h,%h V=%h U=%h",
                                 $realtime, want.luma_tl, want.luma_tr, want.luma_bl,
                                 want.luma_br, want.chroma_v, want.chroma_u);
                        $display("%0t:              got Y=%h,%h,%h,%h V=%h U=%h",
                                 $realtime, o_data.luma_tl, o_data.luma_tr, o_data.luma_bl,
                                 o_data.luma_br, o_data.chroma_v, o_data.chroma_u);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_quad_in q;
        logic     phase_order [NUM_PHASES];
        phase_order = '{ORDER_BGR, ORDER_RGB, ORDER_BGR, ORDER_RGB};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed quads; first rows run on the order left by reset
        for (int k = 0; k < NUM_CASES; k++) begin
            if (quad_cases[k].order != cur_order) begin
                set_order(quad_cases[k].order);
            end
            push_quad(quad_cases[k].quad,
                      quad_cases[k].typed ? quad_cases[k].yuv
                                          : yuv_of_quad(quad_cases[k].quad, cur_order));
        end

        // random phases: first one with a long sink hold, second with no idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_order(phase_order[ph]);
            idle_on = (ph != 1);
            if (ph == 0) begin
                hold_now = 1'b1;
            end
            repeat (PHASE_QUADS) begin
                q = rand_quad();
                push_quad(q, yuv_of_quad(q, cur_order));
            end
        end

        quiesce();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("rgb_quad_to_yuv420 test passed");
        end else begin
            $display("rgb_quad_to_yuv420 test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #800000;
        $display("rgb_quad_to_yuv420 test failed");
        $finish;
    end

endmodule
